// ===== hw/rtl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, codes and reset values for the one-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  // command codes carried in the mode field
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_RESET    = 3'd1;
  localparam logic [2:0] MODE_WRITE    = 3'd2;
  localparam logic [2:0] MODE_READ     = 3'd3;
  localparam logic [2:0] MODE_SKIP_ROM = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_RESET_LOW  = 3'd0;
  localparam logic [2:0] REG_SHORT      = 3'd1;
  localparam logic [2:0] REG_LONG       = 3'd2;
  localparam logic [2:0] REG_READ_LOW   = 3'd3;
  localparam logic [2:0] REG_PRES_WIN   = 3'd4;
  localparam logic [2:0] REG_SKIP_CODE  = 3'd5;

  // register reset values
  localparam logic [9:0] RESET_LOW_DEF = 10'd500;
  localparam logic [9:0] SHORT_DEF     = 10'd8;
  localparam logic [9:0] LONG_DEF      = 10'd90;
  localparam logic [9:0] READ_LOW_DEF  = 10'd2;
  localparam logic [9:0] PRES_WIN_DEF  = 10'd80;
  localparam logic [7:0] SKIP_CODE_DEF = 8'hCC;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RST_LOW = 4'd1,
    PH_RST_REL = 4'd2,
    PH_RST_WAT = 4'd3,
    PH_RST_HI  = 4'd4,
    PH_WR_LOW  = 4'd5,
    PH_WR_REL  = 4'd6,
    PH_RD_LOW  = 4'd7,
    PH_RD_REL  = 4'd8,
    PH_RD_SAMP = 4'd9,
    PH_RD_REC  = 4'd10
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [9:0] short_us;
    logic [9:0] long_us;
    logic [9:0] read_low_us;
    logic [9:0] presence_window_us;
    logic [7:0] skip_rom_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    logic [9:0] time_count;
    logic [2:0] bit_count;
    logic [7:0] shift_byte;
    logic       presence_seen;
    logic [2:0] command_held;
    logic [7:0] read_byte;
  } state_t;

  // a zero duration counts as one tick
  function automatic logic [9:0] dur(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

endpackage

// ===== hw/rtl/owm_step.sv =====
// ----------------------------------------------------------------------------
// owm_step
// Next-state and result logic for one microsecond tick of the bus master.
// ----------------------------------------------------------------------------
module owm_step (
  input  owm_pkg::state_t cur_state,
  input  owm_pkg::cfg_t   cfg,
  input  owm_pkg::item_t  item,
  output owm_pkg::state_t state_nxt,
  output owm_pkg::res_t   result
);

  owm_pkg::state_t st;
  logic            fin;
  logic            drive;
  logic            busy;
  logic            rd_end;
  logic            tick_end;
  logic [9:0]      tc_dec;

  always_comb begin
    st       = cur_state;
    fin      = 1'b0;
    drive    = 1'b0;
    busy     = 1'b0;
    rd_end   = 1'b0;
    tick_end = 1'b0;
    tc_dec   = 10'd0;

    // command start, same tick
    if (st.phase == owm_pkg::PH_IDLE) begin
      case (item.mode)
        owm_pkg::MODE_RESET, owm_pkg::MODE_SKIP_ROM: begin
          st.command_held  = item.mode;
          st.presence_seen = 1'b0;
          st.phase         = owm_pkg::PH_RST_LOW;
          st.time_count    = owm_pkg::dur(cfg.reset_low_us);
        end
        owm_pkg::MODE_WRITE: begin
          st.command_held = item.mode;
          st.shift_byte   = item.data_byte;
          st.bit_count    = 3'd0;
          st.phase        = owm_pkg::PH_WR_LOW;
          st.time_count   = item.data_byte[0] ? owm_pkg::dur(cfg.short_us)
                                              : owm_pkg::dur(cfg.long_us);
        end
        owm_pkg::MODE_READ: begin
          st.command_held = item.mode;
          st.shift_byte   = 8'd0;
          st.bit_count    = 3'd0;
          st.phase        = owm_pkg::PH_RD_LOW;
          st.time_count   = owm_pkg::dur(cfg.read_low_us);
        end
        default: ;
      endcase
    end

    if (st.phase != owm_pkg::PH_IDLE) begin
      busy     = 1'b1;
      tick_end = (st.time_count <= 10'd1);
      tc_dec   = tick_end ? 10'd0 : st.time_count - 10'd1;
      case (st.phase)
        owm_pkg::PH_RST_LOW: begin
          drive = 1'b1;
          if (tick_end) begin
            st.phase      = owm_pkg::PH_RST_REL;
            st.time_count = owm_pkg::dur(cfg.short_us);
          end else begin
            st.time_count = tc_dec;
          end
        end
        owm_pkg::PH_RST_REL: begin
          if (tick_end) begin
            st.phase      = owm_pkg::PH_RST_WAT;
            st.time_count = owm_pkg::dur(cfg.presence_window_us);
          end else begin
            st.time_count = tc_dec;
          end
        end
        owm_pkg::PH_RST_WAT: begin
          if (!item.line_level) begin
            st.presence_seen = 1'b1;
            st.phase         = owm_pkg::PH_RST_HI;
          end else begin
            st.time_count = tc_dec;
            if (tick_end) begin
              st.presence_seen = 1'b0;
              fin              = 1'b1;
            end
          end
        end
        owm_pkg::PH_RST_HI: begin
          if (item.line_level) begin
            if (st.command_held == owm_pkg::MODE_SKIP_ROM) begin
              st.shift_byte = cfg.skip_rom_code;
              st.bit_count  = 3'd0;
              st.phase      = owm_pkg::PH_WR_LOW;
              st.time_count = cfg.skip_rom_code[0] ? owm_pkg::dur(cfg.short_us)
                                                   : owm_pkg::dur(cfg.long_us);
            end else begin
              fin = 1'b1;
            end
          end
        end
        owm_pkg::PH_WR_LOW: begin
          drive = 1'b1;
          if (tick_end) begin
            st.phase      = owm_pkg::PH_WR_REL;
            st.time_count = st.shift_byte[0] ? owm_pkg::dur(cfg.long_us)
                                             : owm_pkg::dur(cfg.short_us);
          end else begin
            st.time_count = tc_dec;
          end
        end
        owm_pkg::PH_WR_REL: begin
          st.time_count = tc_dec;
          if (tick_end) begin
            st.shift_byte = {1'b0, st.shift_byte[7:1]};
            if (st.bit_count == 3'd7) begin
              fin = 1'b1;
            end else begin
              st.bit_count  = st.bit_count + 3'd1;
              st.phase      = owm_pkg::PH_WR_LOW;
              st.time_count = st.shift_byte[0] ? owm_pkg::dur(cfg.short_us)
                                               : owm_pkg::dur(cfg.long_us);
            end
          end
        end
        owm_pkg::PH_RD_LOW: begin
          drive = 1'b1;
          if (tick_end) begin
            st.phase      = owm_pkg::PH_RD_REL;
            st.time_count = owm_pkg::dur(cfg.short_us);
          end else begin
            st.time_count = tc_dec;
          end
        end
        owm_pkg::PH_RD_REL: begin
          st.time_count = tc_dec;
          if (tick_end) begin
            st.phase = owm_pkg::PH_RD_SAMP;
          end
        end
        owm_pkg::PH_RD_SAMP: begin
          st.shift_byte = {item.line_level, st.shift_byte[7:1]};
          st.time_count = owm_pkg::dur(cfg.long_us) - 10'd1;
          if (st.time_count == 10'd0) begin
            rd_end = 1'b1;
          end else begin
            st.phase = owm_pkg::PH_RD_REC;
          end
        end
        owm_pkg::PH_RD_REC: begin
          st.time_count = tc_dec;
          if (tick_end) begin
            rd_end = 1'b1;
          end
        end
        default: begin
          st.phase      = owm_pkg::PH_IDLE;
          st.time_count = 10'd0;
          busy          = 1'b0;
        end
      endcase
    end

    // end of one read slot
    if (rd_end) begin
      if (st.bit_count == 3'd7) begin
        st.read_byte = st.shift_byte;
        fin          = 1'b1;
      end else begin
        st.bit_count  = st.bit_count + 3'd1;
        st.phase      = owm_pkg::PH_RD_LOW;
        st.time_count = owm_pkg::dur(cfg.read_low_us);
      end
    end

    if (fin) begin
      st.phase      = owm_pkg::PH_IDLE;
      st.time_count = 10'd0;
      busy          = 1'b0;
    end
  end

  assign state_nxt        = st;
  assign result.drive_low = drive;
  assign result.busy_res  = busy;
  assign result.done_res  = fin;
  assign result.presence  = st.presence_seen;
  assign result.read_data = st.read_byte;

endmodule

// ===== hw/rtl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master stepped by one microsecond tick per stream transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one microsecond tick: it carries the sampled line
// level and, while the master is idle, a command (bus reset with presence
// detect, write byte, read byte, or skip-ROM, which is a reset followed by
// the skip-ROM byte when a presence pulse was seen). Every input transfer
// yields exactly one output transfer with the line drive for that tick,
// busy, done (on tlast), the latest presence flag and the latest read byte.
// The block takes one tick per clock cycle unless out_tready holds the output
// back. A tick passes the input register, the combinational phase step and
// the output register before its result is presented on the output. Bytes go
// LSB first with short/long slot timing set by the configuration registers;
// a timing register written as zero counts as one. Configuration should be
// written only while no command is running and no tick is in flight.
module one_wire_bus_master (
  input  logic        clk,
  input  logic        rst_n,
  // input ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] line_level, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] mode
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] drive_low, [1] busy_res, [2] presence,
                                  // [10:3] read_data, rest zero
  output logic        out_tlast,  // done_res: last tick of a command
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  // configuration registers
  owm_pkg::cfg_t   cfg_r;

  // input register
  logic            in_valid_r;
  owm_pkg::item_t  in_item_r;

  // bus master state
  owm_pkg::state_t state_r;
  owm_pkg::state_t state_nxt;
  owm_pkg::res_t   res_nxt;

  // output register
  logic            out_valid_r;
  owm_pkg::res_t   out_res_r;

  logic            advance;

  // output stage can take a new result when empty or being drained
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us       <= owm_pkg::RESET_LOW_DEF;
      cfg_r.short_us           <= owm_pkg::SHORT_DEF;
      cfg_r.long_us            <= owm_pkg::LONG_DEF;
      cfg_r.read_low_us        <= owm_pkg::READ_LOW_DEF;
      cfg_r.presence_window_us <= owm_pkg::PRES_WIN_DEF;
      cfg_r.skip_rom_code      <= owm_pkg::SKIP_CODE_DEF;
    end else if (cfg_valid) begin
      case (cfg_index)
        owm_pkg::REG_RESET_LOW: cfg_r.reset_low_us       <= cfg_data;
        owm_pkg::REG_SHORT:     cfg_r.short_us           <= cfg_data;
        owm_pkg::REG_LONG:      cfg_r.long_us            <= cfg_data;
        owm_pkg::REG_READ_LOW:  cfg_r.read_low_us        <= cfg_data;
        owm_pkg::REG_PRES_WIN:  cfg_r.presence_window_us <= cfg_data;
        owm_pkg::REG_SKIP_CODE: cfg_r.skip_rom_code      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // input payload, loaded on every transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.mode       <= in_tuser;
      in_item_r.data_byte  <= in_tdata[7:0];
      in_item_r.line_level <= in_tdata[8];
    end
  end

  // one tick of the phase sequencer
  owm_step u_step (
    .cur_state (state_r),
    .cfg       (cfg_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  // state advances only when the tick moves on to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= owm_pkg::PH_IDLE;
      state_r.time_count    <= 10'd0;
      state_r.bit_count     <= 3'd0;
      state_r.shift_byte    <= 8'd0;
      state_r.presence_seen <= 1'b0;
      state_r.command_held  <= owm_pkg::MODE_TICK;
      state_r.read_byte     <= 8'd0;
    end else if (in_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.done_res;
  assign out_tdata  = {5'd0, out_res_r.read_data, out_res_r.presence,
                       out_res_r.busy_res, out_res_r.drive_low};

  // a finished command is never reported as still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[1])
    else $error("done and busy together");

  // the line is only pulled low while a command runs
  a_drive_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("line driven outside a command");

  // an idle sequencer holds no pending time count
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == owm_pkg::PH_IDLE |-> state_r.time_count == 10'd0)
    else $error("time count left over in idle");

  // a tick held in the input register waits while the output is stalled
  a_hold_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(state_r))
    else $error("tick lost or state moved during stall");

endmodule
